// File: hdl/linear_probe_hash_table_top_macros.svh
// Assertion macros for the linear-probe hash table.
// Used by linear_probe_hash_table_top.sv; no other dependencies.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LPHT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lpht assertion failed");

// Next-cycle implication.
`define LPHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lpht assertion failed");

`endif

// File: hdl/lpht_pkg.sv
// Package for the linear-probe hash table: sizes, codes, request/result types.
// No dependencies.
package lpht_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W      = 31;
    localparam int LOC_W      = 32;
    localparam int MEM_W      = KEY_W + LOC_W;

    // request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SEARCH = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_PROBE
    } t_state;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [LOC_W-1:0] location;
    } t_request;

    typedef struct packed {
        logic [1:0]       status;
        logic [LOC_W-1:0] found_location;
    } t_result;

endpackage

// File: hdl/linear_probe_hash_table_top.sv
// Linear-probe hash table: top level with the slot memory and probe sequencer.
// Depends on lpht_pkg and linear_probe_hash_table_top_macros.svh.
//
// Usage:
//   A request (kind, key, location) is taken at a rising edge with start high
//   and busy low. Kinds: insert, search, delete; any other code leaves the
//   table alone and returns "not found".
//   Exactly one result comes back per request on o_result, qualified by
//   o_result_strobe for one cycle. The receiver cannot stall; results must be
//   taken in the strobe cycle. busy falls in the same cycle the strobe rises,
//   so a new request can be taken while the previous result is on the ports.
// Sequencing (from the accept edge to the strobe):
//   insert: checks p slots from home, p = 1..TABLE_SIZE; occupancy bits
//     are flops, one slot checked per cycle.
//   search/delete: checks p slots, p = 1..TABLE_SIZE; one key/location memory
//     read issued per cycle, compare in the next cycle (read latency), so a
//     miss reads every slot of the ring.
//   unknown kind: answered from idle, no probe. One request at a time; the probe walk sets throughput.
// Reset (synchronous, active low) clears the occupancy bits, so the table
// reads as empty at once; the key/location memory itself is not cleared.
`include "linear_probe_hash_table_top_macros.svh"

module linear_probe_hash_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  lpht_pkg::t_request i_request,
    output logic               busy,
    output logic               o_result_strobe,
    output lpht_pkg::t_result  o_result
);

    // control/sequencer state
    lpht_pkg::t_state r_state, n_state;
    logic [1:0]                 r_kind;
    logic [lpht_pkg::KEY_W-1:0] r_key;
    logic [lpht_pkg::LOC_W-1:0] r_loc;
    logic [lpht_pkg::IDX_W-1:0] r_pos, n_pos;
    logic [lpht_pkg::CNT_W-1:0] r_cnt, n_cnt;

    // compare stage (registered behind the memory read)
    logic                       r_cmp_vld, n_cmp_vld;
    logic [lpht_pkg::IDX_W-1:0] r_cmp_pos;
    logic                       r_cmp_last;

    // storage: occupancy flops plus key/location memory
    logic [lpht_pkg::TABLE_SIZE-1:0] r_used;
    logic [lpht_pkg::MEM_W-1:0]      r_mem [lpht_pkg::TABLE_SIZE];
    logic [lpht_pkg::MEM_W-1:0]      r_rd_data;

    logic               r_strobe;
    lpht_pkg::t_result  r_result;

    // combinational control
    logic                       accept;
    logic                       rd_en;
    logic                       wr_en;
    logic [lpht_pkg::IDX_W-1:0] wr_addr;
    logic [lpht_pkg::MEM_W-1:0] wr_data;
    logic                       set_used, clr_used;
    logic                       finish;
    lpht_pkg::t_result          fin_result;
    logic                       match;
    logic [lpht_pkg::IDX_W-1:0] pos_inc;
    logic [lpht_pkg::IDX_W-1:0] home;

    assign accept  = start && !busy;
    assign busy    = (r_state != lpht_pkg::S_IDLE);
    assign home    = lpht_pkg::IDX_W'(i_request.key % lpht_pkg::TABLE_SIZE);
    assign pos_inc = (r_pos == lpht_pkg::IDX_W'(lpht_pkg::TABLE_SIZE - 1)) ?
                     '0 : r_pos + 1'b1;
    assign match   = r_cmp_vld && r_used[r_cmp_pos] &&
                     (r_rd_data[lpht_pkg::MEM_W-1:lpht_pkg::LOC_W] == r_key);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpht_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_request.kind == lpht_pkg::KIND_INSERT) begin
                        n_state = lpht_pkg::S_INSERT;
                    end else if (i_request.kind inside {lpht_pkg::KIND_SEARCH,
                                                        lpht_pkg::KIND_DELETE}) begin
                        n_state = lpht_pkg::S_PROBE;
                    end
                end
            end
            lpht_pkg::S_INSERT,
            lpht_pkg::S_PROBE: begin
                if (finish) begin
                    n_state = lpht_pkg::S_IDLE;
                end
            end
            default: n_state = lpht_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_cmp_vld  = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_pos;
        wr_data    = {r_key, r_loc};
        set_used   = 1'b0;
        clr_used   = 1'b0;
        finish     = 1'b0;
        fin_result = '{status: lpht_pkg::ST_MISSING, found_location: '0};
        case (r_state)
            lpht_pkg::S_IDLE: begin
                n_pos = home;
                n_cnt = '0;
                // unknown kind answers at once
                if (accept && !(i_request.kind inside {lpht_pkg::KIND_INSERT,
                                                       lpht_pkg::KIND_SEARCH,
                                                       lpht_pkg::KIND_DELETE})) begin
                    finish = 1'b1;
                end
            end
            lpht_pkg::S_INSERT: begin
                if (!r_used[r_pos]) begin
                    wr_en      = 1'b1;
                    set_used   = 1'b1;
                    finish     = 1'b1;
                    fin_result.status = lpht_pkg::ST_OK;
                end else if (r_cnt == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE - 1)) begin
                    finish     = 1'b1;
                    fin_result.status = lpht_pkg::ST_FULL;
                end else begin
                    n_pos = pos_inc;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            lpht_pkg::S_PROBE: begin
                if (match) begin
                    finish = 1'b1;
                    fin_result.status = lpht_pkg::ST_OK;
                    if (r_kind == lpht_pkg::KIND_SEARCH) begin
                        fin_result.found_location = r_rd_data[lpht_pkg::LOC_W-1:0];
                    end else begin
                        // delete: free the slot, no tombstone
                        clr_used = 1'b1;
                        wr_en    = 1'b1;
                        wr_addr  = r_cmp_pos;
                        wr_data  = '0;
                    end
                end else if (r_cmp_vld && r_cmp_last) begin
                    finish = 1'b1;
                end
                if (!match && r_cnt < lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE)) begin
                    rd_en     = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_pos     = pos_inc;
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lpht_pkg::S_IDLE;
            r_cmp_vld <= 1'b0;
            r_strobe  <= 1'b0;
            r_used    <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_strobe  <= finish;
            if (set_used) begin
                r_used[r_pos] <= 1'b1;
            end
            if (clr_used) begin
                r_used[r_cmp_pos] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_cnt      <= n_cnt;
        r_cmp_pos  <= r_pos;
        r_cmp_last <= (r_cnt == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE - 1));
        if (accept) begin
            r_kind <= i_request.kind;
            r_key  <= i_request.key;
            r_loc  <= i_request.location;
        end
        if (finish) begin
            r_result <= fin_result;
        end
    end

    // key/location memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_pos];
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    // checks
    `LPHT_ASSERT_NEXT(a_accept_busy_or_done, i_clk, i_rst_n, accept, busy || o_result_strobe)
    `LPHT_ASSERT_SAME(a_fail_zero_loc, i_clk, i_rst_n,
        o_result_strobe && o_result.status != lpht_pkg::ST_OK, o_result.found_location == '0)
    `LPHT_ASSERT_SAME(a_one_write_kind, i_clk, i_rst_n, wr_en, set_used != clr_used)

endmodule

// File: test/tb.sv
// Self-checking bench for linear_probe_hash_table_top: directed table, then random phases.
// Depends on lpht_pkg and the RTL top; predicts results with a local slot model unless a row gives its own.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // the package has no name for the fourth kind code; the block must ignore it
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         NUM_ROWS    = 26;
    localparam int         NUM_PHASES  = 4;
    localparam int         PHASE_ITEMS = 350;
    localparam int         POOL_DEPTH  = 12;

    typedef struct {
        lpht_pkg::t_request req;
        bit                 typed;    // expectation is written in the row itself
        lpht_pkg::t_result  want;
    } t_plan_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    lpht_pkg::t_request i_request;
    logic               busy;
    logic               o_result_strobe;
    lpht_pkg::t_result  o_result;

    // copy of the slot memory, kept in step with accepted requests
    logic [lpht_pkg::KEY_W-1:0] model_key  [lpht_pkg::TABLE_SIZE];
    logic [lpht_pkg::LOC_W-1:0] model_loc  [lpht_pkg::TABLE_SIZE];
    bit                         model_used [lpht_pkg::TABLE_SIZE];

    lpht_pkg::t_result pending_results[$];
    int unsigned       fail_count = 0;
    int unsigned       gap_pct    = 0;

    // travels alongside the request; a typed row overrides the prediction
    bit                hold_typed;
    lpht_pkg::t_result hold_want;

    t_plan_row                  ops_plan [NUM_ROWS];
    logic [lpht_pkg::KEY_W-1:0] key_pool [POOL_DEPTH];

    linear_probe_hash_table_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_request       (i_request),
        .busy            (busy),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Applies one request to the model and returns the result the block owes.
    // Insert takes the first free slot from home; search and delete act on
    // the first used slot with the key over the whole ring.
    function automatic lpht_pkg::t_result hash_table_apply(lpht_pkg::t_request r);
        lpht_pkg::t_result res;
        int                pos;
        int                hit;
        bit                placed;
        res.status         = lpht_pkg::ST_MISSING;
        res.found_location = '0;
        pos                = int'(r.key % lpht_pkg::TABLE_SIZE);
        hit                = -1;
        placed             = 1'b0;
        case (r.kind)
            lpht_pkg::KIND_INSERT: begin
                res.status = lpht_pkg::ST_FULL;
                for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++) begin
                    if (!placed && !model_used[pos]) begin
                        model_used[pos] = 1'b1;
                        model_key[pos]  = r.key;
                        model_loc[pos]  = r.location;
                        res.status      = lpht_pkg::ST_OK;
                        placed          = 1'b1;
                    end
                    pos = (pos + 1) % lpht_pkg::TABLE_SIZE;
                end
            end
            lpht_pkg::KIND_SEARCH, lpht_pkg::KIND_DELETE: begin
                for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++) begin
                    if (hit < 0 && model_used[pos] && model_key[pos] == r.key)
                        hit = pos;
                    pos = (pos + 1) % lpht_pkg::TABLE_SIZE;
                end
                if (hit >= 0) begin
                    res.status = lpht_pkg::ST_OK;
                    if (r.kind == lpht_pkg::KIND_SEARCH) begin
                        res.found_location = model_loc[hit];
                    end else begin
                        model_used[hit] = 1'b0;
                        model_key[hit]  = '0;
                        model_loc[hit]  = '0;
                    end
                end
            end
            default: ;  // unused kind: table untouched, reported as not found
        endcase
        return res;
    endfunction

    // Everything is sampled at the rising edge; inputs only move on the falling
    // edge and the block updates through flops, so the values read here are
    // the ones the block saw. The strobe is retired before a new request is
    // booked, since busy drops in the strobe cycle and both can share an edge.
    always @(posedge i_clk) begin
        lpht_pkg::t_result want;
        lpht_pkg::t_result model_out;
        if (i_rst_n) begin
            if (o_result_strobe) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing outstanding: status %0d location %h",
                           o_result.status, o_result.found_location);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, o_result.status);
                        fail_count++;
                    end
                    if (o_result.found_location !== want.found_location) begin
                        $error("found_location: expected %h, actual %h",
                               want.found_location, o_result.found_location);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                // the model always runs so its state tracks the block
                model_out = hash_table_apply(i_request);
                pending_results.push_back(hold_typed ? hold_want : model_out);
            end
        end
    end

    // Offers one request and returns once it has been taken. Before raising
    // start the sender may sit idle for a random number of cycles.
    task automatic issue(lpht_pkg::t_request r, bit typed, lpht_pkg::t_result want);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start      <= 1'b1;
        i_request  <= r;
        hold_typed <= typed;
        hold_want  <= want;
        do @(posedge i_clk); while (busy);
    endtask

    // Random request drawn mostly from the key pool so that hits, duplicate
    // inserts and deletes of live keys are common; the rest are fresh keys.
    task automatic issue_random(int ins_pct, int srch_pct, int del_pct);
        lpht_pkg::t_request r;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < ins_pct)
            r.kind = lpht_pkg::KIND_INSERT;
        else if (pick < ins_pct + srch_pct)
            r.kind = lpht_pkg::KIND_SEARCH;
        else if (pick < ins_pct + srch_pct + del_pct)
            r.kind = lpht_pkg::KIND_DELETE;
        else
            r.kind = KIND_UNUSED;
        if ($urandom_range(99) < 85)
            r.key = key_pool[$urandom_range(POOL_DEPTH - 1)];
        else
            r.key = lpht_pkg::KEY_W'($urandom());
        r.location = $urandom();
        issue(r, 1'b0, '{lpht_pkg::ST_OK, '0});
    endtask

    initial begin
        // the bench's own main flow
        int base;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_request  = '0;
        hold_typed = 1'b0;
        hold_want  = '{lpht_pkg::ST_OK, '0};
        for (int s = 0; s < lpht_pkg::TABLE_SIZE; s++) begin
            model_used[s] = 1'b0;
            model_key[s]  = '0;
            model_loc[s]  = '0;
        end

        // Directed rows. Key 0 and the all-ones key are ordinary keys;
        // keys ending in hex 0 all share home slot 0 and build one long
        // cluster that fills the table, then the table-full insert, a
        // duplicate key found in probe order after a wrap, and a miss
        // that walks the whole ring.
        ops_plan = '{
            '{'{lpht_pkg::KIND_SEARCH, 31'd5,        32'd0},        1'b1,
              '{lpht_pkg::ST_MISSING, 32'd0}},
            '{'{lpht_pkg::KIND_DELETE, 31'd5,        32'd0},        1'b1,
              '{lpht_pkg::ST_MISSING, 32'd0}},
            '{'{KIND_UNUSED,           31'h7FFFFFFF, 32'hFFFFFFFF}, 1'b1,
              '{lpht_pkg::ST_MISSING, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'd0,        32'hFFFFFFFF}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_SEARCH, 31'd0,        32'd0},        1'b1,
              '{lpht_pkg::ST_OK, 32'hFFFFFFFF}},
            '{'{lpht_pkg::KIND_INSERT, 31'h7FFFFFFF, 32'd0},        1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h7FFFFFFF, 32'h12345678}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_SEARCH, 31'h7FFFFFFF, 32'd0},        1'b0,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h00000010, 32'h80000000}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h7FFFFFF0, 32'h00000001}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h2AAAAAA0, 32'hAAAAAAAA}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h55555550, 32'h55555555}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h40000000, 32'h7FFFFFFF}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h00000020, 32'hDEADBEEF}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h0F0F0F00, 32'h0F0F0F0F}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h70F0F0F0, 32'hF0F0F0F0}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h12345670, 32'h00000002}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h3C3C3C30, 32'hC3C3C3C3}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h66666660, 32'h99999999}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h01010100, 32'hFEFEFEFE}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h5A5A5A50, 32'hA5A5A5A5}, 1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_INSERT, 31'h00000030, 32'hCAFEF00D}, 1'b1,
              '{lpht_pkg::ST_FULL, 32'd0}},
            '{'{lpht_pkg::KIND_SEARCH, 31'h00000010, 32'd0},        1'b0,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_DELETE, 31'h7FFFFFFF, 32'd0},        1'b1,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_SEARCH, 31'h7FFFFFFF, 32'd0},        1'b0,
              '{lpht_pkg::ST_OK, 32'd0}},
            '{'{lpht_pkg::KIND_SEARCH, 31'h00000055, 32'd0},        1'b1,
              '{lpht_pkg::ST_MISSING, 32'd0}}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (ops_plan[i])
            issue(ops_plan[i].req, ops_plan[i].typed, ops_plan[i].want);

        // Random phases. The receiver cannot hold results off, so only the
        // sender idles: none, heavy, none, light. Op mixes alternate between
        // filling toward full, balanced traffic and draining.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            base = $urandom_range(lpht_pkg::TABLE_SIZE - 1);
            foreach (key_pool[j]) begin
                key_pool[j] = lpht_pkg::KEY_W'($urandom());
                // cluster homes around one spot so probe chains get long
                key_pool[j][lpht_pkg::IDX_W-1:0] =
                    lpht_pkg::IDX_W'((base + $urandom_range(5)) % lpht_pkg::TABLE_SIZE);
            end
            if (ph == 0) begin
                key_pool[0] = '0;
                key_pool[1] = '1;
            end
            case (ph)
                0: gap_pct = 0;
                1: gap_pct = 48;
                2: gap_pct = 0;
                default: gap_pct = 12;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                case (ph)
                    1: issue_random(60, 25, 13);
                    2: issue_random(20, 35, 43);
                    default: issue_random(40, 35, 22);
                endcase
            end
        end

        @(negedge i_clk);
        start <= 1'b0;

        // drain, then leave room for a late or extra result
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (lpht_pkg::TABLE_SIZE + 4) @(posedge i_clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // ~1.4k requests in all; the timeout allows about ten times
    // the expected run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lpht_pkg.sv
hdl/linear_probe_hash_table_top.sv
test/tb.sv
